// File: hdl/gfbs_pkg.sv
// ----------------------------------------------------------------------------
// gfbs_pkg: shared types and constants of the grid feature bucket selector
// Holds the point and cell layouts, the opcode and register index codes and
// the control state type used by the core.
// ----------------------------------------------------------------------------
`default_nettype none

package gfbs_pkg;

    localparam int POS_W  = 16;   // unsigned 12.4 fixed point coordinate
    localparam int FRAC_W = 4;
    localparam int PIX_W  = POS_W - FRAC_W;
    localparam int CNT_W  = 16;
    localparam int ID_W   = 32;
    localparam int CFG_W  = 12;

    // First member lands in the top bits: x_pos is bit 0 upward.
    typedef struct packed {
        logic [ID_W-1:0]  point_id;
        logic [CNT_W-1:0] track_count;
        logic [POS_W-1:0] last_kf_y;
        logic [POS_W-1:0] last_kf_x;
        logic [POS_W-1:0] y_pos;
        logic [POS_W-1:0] x_pos;
    } point_t;

    localparam int POINT_W = $bits(point_t);

    typedef struct packed {
        logic   occupied;
        point_t pt;
    } cell_t;

    localparam int CELL_W = $bits(cell_t);

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DRAIN  = 1'b1;

    localparam logic CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic CFG_IMAGE_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] IMAGE_WIDTH_RST  = 12'd640;
    localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RST = 12'd480;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN
    } state_t;

endpackage

`default_nettype wire

// File: hdl/gfbs_ram.sv
// ----------------------------------------------------------------------------
// gfbs_ram: generic single-write, single-read synchronous RAM
// One write and one read port; read data is registered, and a read of the
// address being written returns the old contents.
// ----------------------------------------------------------------------------
`default_nettype none

module gfbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: hdl/gfbs_locate.sv
// ----------------------------------------------------------------------------
// gfbs_locate: map a point position to its grid cell address
// Takes the pixel part of the coordinates, divides by the cell size through
// an exact reciprocal multiply and checks the image and grid bounds.
// ----------------------------------------------------------------------------
`default_nettype none

module gfbs_locate #(
    parameter int CELL_SIZE = 32,
    parameter int MAX_COLS  = 64,
    parameter int MAX_ROWS  = 64,
    parameter int COL_W     = 6,
    parameter int ROW_W     = 6
) (
    input  wire logic [gfbs_pkg::POS_W-1:0] x_pos,
    input  wire logic [gfbs_pkg::POS_W-1:0] y_pos,
    input  wire logic [gfbs_pkg::CFG_W-1:0] image_width,
    input  wire logic [gfbs_pkg::CFG_W-1:0] image_height,
    output logic                            in_grid,
    output logic [ROW_W+COL_W-1:0]          cell_addr
);

    import gfbs_pkg::*;

    // Exact for any PIX_W-bit numerator and a divisor up to 2**7.
    localparam int DIV_SHIFT = PIX_W + 7;
    localparam int RECIP     = ((1 << DIV_SHIFT) + CELL_SIZE - 1) / CELL_SIZE;
    localparam int RECIP_W   = $clog2(RECIP + 1);
    localparam int PROD_W    = PIX_W + RECIP_W;
    localparam int Q_W       = PROD_W - DIV_SHIFT;
    localparam int EXT_W     = Q_W + ROW_W + COL_W;

    logic [PIX_W-1:0]  px;
    logic [PIX_W-1:0]  py;
    logic [PROD_W-1:0] prod_x;
    logic [PROD_W-1:0] prod_y;
    logic [Q_W-1:0]    col_q;
    logic [Q_W-1:0]    row_q;
    logic [EXT_W-1:0]  col_ext;
    logic [EXT_W-1:0]  row_ext;

    always_comb
    begin
        px      = x_pos[POS_W-1:FRAC_W];
        py      = y_pos[POS_W-1:FRAC_W];
        prod_x  = PROD_W'(px) * PROD_W'(RECIP);
        prod_y  = PROD_W'(py) * PROD_W'(RECIP);
        col_q   = prod_x[PROD_W-1:DIV_SHIFT];
        row_q   = prod_y[PROD_W-1:DIV_SHIFT];
        col_ext = EXT_W'(col_q);
        row_ext = EXT_W'(row_q);
        in_grid = (px < image_width) && (py < image_height)
               && (32'(col_q) < 32'(MAX_COLS))
               && (32'(row_q) < 32'(MAX_ROWS));
        // Rows above columns keeps the address order row-major.
        cell_addr = {row_ext[ROW_W-1:0], col_ext[COL_W-1:0]};
    end

endmodule

`default_nettype wire

// File: hdl/grid_feature_bucket_select_core.sv
// ----------------------------------------------------------------------------
// grid_feature_bucket_select_core: grid bucketing of tracked feature points
// Keeps the best-tracked point per image cell in one RAM and drains the
// occupied cells in row-major order.
// ----------------------------------------------------------------------------
// Insert items (tuser = 0) carry a point; the point lands in a CELL_SIZE x
// CELL_SIZE pixel cell and replaces the stored one only if its track count is
// strictly larger, so the first of equal points stays. Points outside the
// configured image or the grid are dropped silently. Inserts produce no item
// and are taken one per cycle while the core is idle: a read of the cell RAM,
// then compare and write in the next cycle, with the last write forwarded to a
// back-to-back hit on the same cell. A drain item (tuser = 1) walks the cell
// RAM from the saved cursor, one cell per cycle while the output register is
// empty, and returns the first occupied cell (found) and empties it, or an end
// item (scan_done, all fields zero) that rewinds the cursor. A drain waits
// while an earlier result still sits in the output register. Inputs are held
// off during a drain. After reset a clearing pass writes every RAM entry, one
// per cycle, before the first item is taken; register writes are taken at any
// time. Cell address = {row, col}, so the grid size sets the RAM depth.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_feature_bucket_select_core #(
    parameter int CELL_SIZE = 32,
    parameter int MAX_COLS  = 64,
    parameter int MAX_ROWS  = 64
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // configuration write port
    input  wire logic                              cfg_we,
    input  wire logic                              cfg_index,
    input  wire logic [gfbs_pkg::CFG_W-1:0]        cfg_data,
    // input stream
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // x_pos, y_pos, last_kf_x, last_kf_y, track_count, point_id
    input  wire logic [gfbs_pkg::POINT_W-1:0]      s_tdata,
    // opcode
    input  wire logic [0:0]                        s_tuser,
    // result stream
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // out_x, out_y, out_kf_x, out_kf_y, out_count, out_id
    output logic      [gfbs_pkg::POINT_W-1:0]      m_tdata,
    // found, scan_done
    output logic      [1:0]                        m_tuser
);

    import gfbs_pkg::*;

    localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int ADDR_W = ROW_W + COL_W;
    localparam int DEPTH  = 1 << ADDR_W;

    // Control state.
    state_t              state_reg;
    state_t              state_next;
    logic [ADDR_W-1:0]   clr_ptr_reg;
    logic [ADDR_W:0]     scan_ptr_reg;
    logic [ADDR_W:0]     cursor_reg;
    logic [CFG_W-1:0]    width_reg;
    logic [CFG_W-1:0]    height_reg;

    // Compare/write stage.
    logic                s2_valid_reg;
    logic                s2_scan_reg;
    logic [ADDR_W-1:0]   s2_addr_reg;
    point_t              s2_point_reg;

    // Last RAM write, for forwarding.
    logic                lw_valid_reg;
    logic [ADDR_W-1:0]   lw_addr_reg;
    cell_t               lw_data_reg;

    // Output register.
    logic                m_valid_reg;
    point_t              m_data_reg;
    logic                m_found_reg;
    logic                m_done_reg;

    logic                in_acc;
    logic                drain_acc;
    point_t              point_in;
    logic                loc_ok;
    logic [ADDR_W-1:0]   loc_addr;
    logic                ins_issue;
    logic                scan_issue;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic [CELL_W-1:0]   rd_data;
    cell_t               cur_cell;
    logic                keep;
    logic                scan_hit;
    logic                scan_end;
    logic                out_load;
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    cell_t               wr_data;

    gfbs_locate #(
        .CELL_SIZE (CELL_SIZE),
        .MAX_COLS  (MAX_COLS),
        .MAX_ROWS  (MAX_ROWS),
        .COL_W     (COL_W),
        .ROW_W     (ROW_W)
    ) u_locate (
        .x_pos        (point_in.x_pos),
        .y_pos        (point_in.y_pos),
        .image_width  (width_reg),
        .image_height (height_reg),
        .in_grid      (loc_ok),
        .cell_addr    (loc_addr)
    );

    gfbs_ram #(
        .WIDTH (CELL_W),
        .DEPTH (DEPTH)
    ) u_cell_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // Handshake outputs.
    always_comb
    begin
        s_tready = (state_reg == ST_IDLE);
        m_tvalid = m_valid_reg;
        m_tdata  = m_data_reg;
        m_tuser  = {m_done_reg, m_found_reg};
    end

    // Issue side: pick the RAM read for this cycle.
    always_comb
    begin
        point_in   = point_t'(s_tdata);
        in_acc     = s_tvalid && s_tready;
        drain_acc  = in_acc && (s_tuser[0] == OP_DRAIN);
        ins_issue  = in_acc && (s_tuser[0] == OP_INSERT) && loc_ok;
        // Walk only while the output register is empty; nothing else fills it.
        scan_issue = (state_reg == ST_SCAN) && !m_valid_reg && !scan_ptr_reg[ADDR_W];
        rd_en      = ins_issue || scan_issue;
        rd_addr    = ins_issue ? loc_addr : scan_ptr_reg[ADDR_W-1:0];
    end

    // Compare/write side.
    always_comb
    begin
        // The RAM returns old data when the previous cycle wrote the same cell.
        if (lw_valid_reg && (lw_addr_reg == s2_addr_reg))
        begin
            cur_cell = lw_data_reg;
        end
        else
        begin
            cur_cell = cell_t'(rd_data);
        end
        keep     = s2_valid_reg && !s2_scan_reg
                && (!cur_cell.occupied || (s2_point_reg.track_count > cur_cell.pt.track_count));
        scan_hit = s2_valid_reg && s2_scan_reg && cur_cell.occupied;
        scan_end = (state_reg == ST_SCAN) && !m_valid_reg && scan_ptr_reg[ADDR_W]
                && !(s2_valid_reg && s2_scan_reg);
        out_load = scan_hit || scan_end;

        wr_en   = 1'b0;
        wr_addr = s2_addr_reg;
        wr_data = '0;
        if (state_reg == ST_CLEAR)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_ptr_reg;
        end
        else if (scan_hit)
        begin
            wr_en = 1'b1;
        end
        else if (keep)
        begin
            wr_en            = 1'b1;
            wr_data.occupied = 1'b1;
            wr_data.pt       = s2_point_reg;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_ptr_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (drain_acc)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_ptr_reg  <= '0;
            scan_ptr_reg <= '0;
            cursor_reg   <= '0;
            width_reg    <= IMAGE_WIDTH_RST;
            height_reg   <= IMAGE_HEIGHT_RST;
            s2_valid_reg <= 1'b0;
            lw_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we && (cfg_index == CFG_IMAGE_WIDTH))
            begin
                width_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == CFG_IMAGE_HEIGHT))
            begin
                height_reg <= cfg_data;
            end

            if (state_reg == ST_CLEAR)
            begin
                clr_ptr_reg <= clr_ptr_reg + 1'b1;
            end

            // Start the walk at the saved cursor, then advance per read.
            if (drain_acc)
            begin
                scan_ptr_reg <= cursor_reg;
            end
            else if (scan_issue)
            begin
                scan_ptr_reg <= scan_ptr_reg + 1'b1;
            end

            if (scan_hit)
            begin
                cursor_reg <= {1'b0, s2_addr_reg} + 1'b1;
            end
            else if (scan_end)
            begin
                cursor_reg <= '0;
            end

            // Drop the read already in flight behind a hit.
            s2_valid_reg <= rd_en && !scan_hit;
            lw_valid_reg <= wr_en;

            if (out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        s2_scan_reg  <= scan_issue;
        s2_addr_reg  <= rd_addr;
        s2_point_reg <= point_in;
        lw_addr_reg  <= wr_addr;
        lw_data_reg  <= wr_data;
        if (out_load)
        begin
            m_data_reg  <= scan_hit ? cur_cell.pt : '0;
            m_found_reg <= scan_hit;
            m_done_reg  <= !scan_hit;
        end
    end

`ifndef SYNTHESIS
    a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser[0] != m_tuser[1]))
        else $error("result item is neither a point nor an end marker");

    a_scan_in_scan_state: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && s2_scan_reg) |-> (state_reg == ST_SCAN))
        else $error("cell walk read outside a drain");

    a_load_into_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> !m_valid_reg)
        else $error("result loaded over a waiting result");

    a_rewind_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        scan_end |=> (cursor_reg == '0) && (state_reg == ST_IDLE))
        else $error("cursor not rewound after end marker");
`endif

endmodule

`default_nettype wire
